@@ hw/rtl/msd_pkg.sv @@
// Shared types, constants and helper functions for the motion stall detector.
package msd_pkg;

    localparam int CFG_W       = 31;
    localparam int CFG_ADDR_W  = 4;
    localparam int CNT_W       = 8;
    localparam int VAL_W       = 32;
    localparam int IN_TDATA_W  = 168;
    localparam int OUT_TDATA_W = 8;
    localparam int CAUSE_W     = 4;

    // Bit positions in the input word.
    localparam int IN_ACTIVE_LSB = 0;
    localparam int IN_DE_LSB     = 1;
    localparam int IN_AE_LSB     = IN_DE_LSB + VAL_W;
    localparam int IN_LV_LSB     = IN_AE_LSB + VAL_W;
    localparam int IN_AV_LSB     = IN_LV_LSB + VAL_W;
    localparam int IN_DC_LSB     = IN_AV_LSB + VAL_W;
    localparam int IN_USED_W     = IN_DC_LSB + VAL_W;

    // Bits of the cause mask.
    localparam int CAUSE_DIST_JUMP  = 0;
    localparam int CAUSE_DIST_FAULT = 1;
    localparam int CAUSE_ANG_JUMP   = 2;
    localparam int CAUSE_ANG_FAULT  = 3;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_DIST_JUMP     = 4'd0,
        REG_ANG_JUMP      = 4'd1,
        REG_CMD_STALL     = 4'd2,
        REG_REVERSE_SPEED = 4'd3,
        REG_STALL_SPEED   = 4'd4,
        REG_ANG_FLOOR     = 4'd5,
        REG_TURN_FLOOR    = 4'd6,
        REG_DETECT_EN     = 4'd7
    } cfg_reg_t;

    typedef enum logic {
        FUNC_TICK  = 1'b0,
        FUNC_CLEAR = 1'b1
    } func_t;

    typedef struct packed {
        logic [CFG_W-1:0] dist_jump;
        logic [CFG_W-1:0] ang_jump;
        logic [CFG_W-1:0] cmd_stall;
        logic [CFG_W-1:0] reverse_speed;
        logic [CFG_W-1:0] stall_speed;
        logic [CFG_W-1:0] ang_floor;
        logic [CFG_W-1:0] turn_floor;
        logic             detect_en;
    } msd_cfg_t;

    typedef struct packed {
        func_t                   func;
        logic                    active;
        logic signed [VAL_W-1:0] dist_err;
        logic signed [VAL_W-1:0] ang_err;
        logic signed [VAL_W-1:0] lin_speed;
        logic signed [VAL_W-1:0] ang_speed;
        logic signed [VAL_W-1:0] dist_cmd;
    } msd_item_t;

    typedef struct packed {
        logic               stuck;
        logic               stuck_new;
        logic [CAUSE_W-1:0] cause_mask;
    } msd_result_t;

    // Magnitude of a signed 32-bit value; the most negative value maps to 2^31.
    function automatic logic [VAL_W-1:0] mag32(input logic signed [VAL_W-1:0] x);
        logic [VAL_W-1:0] neg;
        neg = VAL_W'(-x);
        return x[VAL_W-1] ? neg : VAL_W'(x);
    endfunction

    // Magnitude of the exact difference a - b, kept at 33 bits.
    function automatic logic [VAL_W:0] mag_diff(input logic signed [VAL_W-1:0] a,
                                                input logic signed [VAL_W-1:0] b);
        logic [VAL_W:0] diff;
        diff = {a[VAL_W-1], a} - {b[VAL_W-1], b};
        return diff[VAL_W] ? (VAL_W+1)'(-diff) : diff;
    endfunction

    // True when the signs (-1, 0, +1) of the two values differ.
    function automatic logic sign_differs(input logic signed [VAL_W-1:0] a,
                                          input logic signed [VAL_W-1:0] b);
        logic a_zero;
        logic b_zero;
        a_zero = (a == '0);
        b_zero = (b == '0);
        return (a_zero != b_zero) || (!a_zero && (a[VAL_W-1] != b[VAL_W-1]));
    endfunction

endpackage

@@ hw/rtl/motion_stall_detector_top.sv @@
// Top level of the motion stall detector: stream ports, input and result registers.
//
// Usage. Each input word on the s_ channel is one control tick (s_tuser = 0) or a
// clear of the stuck state (s_tuser = 1). Every input word yields exactly one result
// word on the m_ channel, in order: the sticky stuck flag, a flag that says the stall
// was detected on this very tick, and a four-bit cause mask (distance jump, distance
// fault, angle jump, angle fault from bit 0 up).
// Thresholds are written through the plain configuration port (cfg_wr_en, cfg_addr,
// cfg_wdata); writes take effect on the next clock and should only be made while no
// word is in flight. Writes to an index above 7 are dropped.
// A word accepted into the input register is checked there, and its result is
// registered in the result register, whose valid flag drives m_tvalid. Throughput is
// one word per cycle while the receiver does not stall: the checks are a few compares
// and subtracts plus two counter increments between the input register and the result
// register, and the history and counter state update on the same step as the result.
// When the receiver stalls, the result register holds its word and the input register
// holds one more; s_tready drops only when both are full and m_tready is low.
// Reset (aresetn low, synchronous) empties both registers, clears the counters, the
// error history and the stuck flag, and loads the thresholds with their defaults.
module motion_stall_detector_top
    import msd_pkg::*;
#(
    parameter int FAIL_LIMIT = 50
)
(
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    // Fields from bit 0 up: active, distance_error, angle_error, linear_speed,
    // angular_speed, distance_command; bits 167:161 are zero.
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // Fields from bit 0 up: func.
    input  logic                   s_tuser,

    output logic                   m_tvalid,
    input  logic                   m_tready,
    // Fields from bit 0 up: stuck, stuck_new, cause_mask; bits 7:6 are zero.
    output logic [OUT_TDATA_W-1:0] m_tdata,

    input  logic                   cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [CFG_W-1:0]       cfg_wdata
);

    msd_cfg_t    cfg;
    msd_item_t   in_item;
    msd_item_t   item_reg;
    logic        in_valid_reg, in_valid_next;
    msd_result_t result;
    msd_result_t out_reg;
    logic        out_valid_reg, out_valid_next;
    logic        advance;
    logic        step;
    logic        s_accept;

    // Unpack the input word into its fields.
    always_comb begin
        in_item.func      = func_t'(s_tuser);
        in_item.active    = s_tdata[IN_ACTIVE_LSB];
        in_item.dist_err  = s_tdata[IN_DE_LSB +: VAL_W];
        in_item.ang_err   = s_tdata[IN_AE_LSB +: VAL_W];
        in_item.lin_speed = s_tdata[IN_LV_LSB +: VAL_W];
        in_item.ang_speed = s_tdata[IN_AV_LSB +: VAL_W];
        in_item.dist_cmd  = s_tdata[IN_DC_LSB +: VAL_W];
    end

    // The result register can take a new word when it is empty or being drained.
    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    msd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    msd_core #(
        .FAIL_LIMIT (FAIL_LIMIT)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
        if (s_accept) begin
            item_reg <= in_item;
        end
        if (step) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - CAUSE_W - 2){1'b0}},
                       out_reg.cause_mask, out_reg.stuck_new, out_reg.stuck};

    // A fresh detection always carries a cause and leaves the flag set.
    a_new_has_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.stuck_new |-> out_reg.cause_mask != '0 && out_reg.stuck)
        else $error("stuck_new without cause or flag");

    a_cause_is_new: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.cause_mask != '0 |-> out_reg.stuck_new)
        else $error("cause reported without stuck_new");

    // A stalled result keeps the pending input word in place.
    a_input_held: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(item_reg))
        else $error("pending input word lost during stall");

    // Every word that leaves the input register lands in the result register.
    a_step_fills_out: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> out_valid_reg)
        else $error("result register missed a word");

endmodule

@@ hw/rtl/msd_cfg.sv @@
// Configuration register file of the motion stall detector.
module msd_cfg
    import msd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata,
    output msd_cfg_t              cfg
);

    msd_cfg_t cfg_reg;
    msd_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_addr))
                REG_DIST_JUMP:     cfg_next.dist_jump     = cfg_wdata;
                REG_ANG_JUMP:      cfg_next.ang_jump      = cfg_wdata;
                REG_CMD_STALL:     cfg_next.cmd_stall     = cfg_wdata;
                REG_REVERSE_SPEED: cfg_next.reverse_speed = cfg_wdata;
                REG_STALL_SPEED:   cfg_next.stall_speed   = cfg_wdata;
                REG_ANG_FLOOR:     cfg_next.ang_floor     = cfg_wdata;
                REG_TURN_FLOOR:    cfg_next.turn_floor    = cfg_wdata;
                REG_DETECT_EN:     cfg_next.detect_en     = cfg_wdata[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dist_jump     <= CFG_W'(16384);
            cfg_reg.ang_jump      <= CFG_W'(183501);
            cfg_reg.cmd_stall     <= CFG_W'(40960);
            cfg_reg.reverse_speed <= CFG_W'(16384);
            cfg_reg.stall_speed   <= CFG_W'(9830);
            cfg_reg.ang_floor     <= CFG_W'(6554);
            cfg_reg.turn_floor    <= CFG_W'(262);
            cfg_reg.detect_en     <= 1'b1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ hw/rtl/msd_core.sv @@
// Stall checks, fault counters, error history and the sticky stuck flag.
module msd_core
    import msd_pkg::*;
#(
    parameter int FAIL_LIMIT = 50
)
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  msd_item_t   item,
    input  msd_cfg_t    cfg,
    output msd_result_t result
);

    localparam logic [CNT_W-1:0] LIMIT = CNT_W'(FAIL_LIMIT);

    logic signed [VAL_W-1:0] last_dist_err_reg, last_dist_err_next;
    logic signed [VAL_W-1:0] last_ang_err_reg, last_ang_err_next;
    logic [CNT_W-1:0]        dist_fails_reg, dist_fails_next;
    logic [CNT_W-1:0]        ang_fails_reg, ang_fails_next;
    logic                    stuck_reg, stuck_next;

    logic [VAL_W-1:0]   lin_mag;
    logic [VAL_W-1:0]   cmd_mag;
    logic [VAL_W-1:0]   ang_mag;
    logic [VAL_W-1:0]   turn_mag;
    logic               dist_fault;
    logic               ang_fault;
    logic               checking;
    logic [CNT_W-1:0]   dist_inc;
    logic [CNT_W-1:0]   ang_inc;
    logic [CAUSE_W-1:0] cause;

    always_comb begin
        lin_mag  = mag32(item.lin_speed);
        cmd_mag  = mag32(item.dist_cmd);
        ang_mag  = mag32(item.ang_err);
        turn_mag = mag32(item.ang_speed);
        dist_inc = dist_fails_reg + 1'b1;
        ang_inc  = ang_fails_reg + 1'b1;

        dist_fault = (sign_differs(item.dist_err, item.lin_speed) &&
                      (lin_mag > {1'b0, cfg.reverse_speed})) ||
                     ((cmd_mag > {1'b0, cfg.cmd_stall}) &&
                      (lin_mag < {1'b0, cfg.stall_speed}));
        ang_fault  = (ang_mag > {1'b0, cfg.ang_floor}) &&
                     (sign_differs(item.ang_err, item.ang_speed) ||
                      (turn_mag < {1'b0, cfg.turn_floor}));

        checking = item.active && cfg.detect_en && !stuck_reg;

        last_dist_err_next = last_dist_err_reg;
        last_ang_err_next  = last_ang_err_reg;
        dist_fails_next    = dist_fails_reg;
        ang_fails_next     = ang_fails_reg;
        stuck_next         = stuck_reg;
        cause              = '0;

        if (item.func == FUNC_CLEAR) begin
            dist_fails_next = '0;
            ang_fails_next  = '0;
            stuck_next      = 1'b0;
        end else begin
            last_dist_err_next = item.dist_err;
            last_ang_err_next  = item.ang_err;
            if (checking) begin
                cause[CAUSE_DIST_JUMP] =
                    mag_diff(item.dist_err, last_dist_err_reg) > {2'b00, cfg.dist_jump};
                cause[CAUSE_ANG_JUMP] =
                    mag_diff(item.ang_err, last_ang_err_reg) > {2'b00, cfg.ang_jump};
                if (dist_fault) begin
                    if (dist_inc > LIMIT) begin
                        cause[CAUSE_DIST_FAULT] = 1'b1;
                        dist_fails_next         = '0;
                    end else begin
                        dist_fails_next = dist_inc;
                    end
                end else begin
                    dist_fails_next = '0;
                end
                if (ang_fault) begin
                    if (ang_inc > LIMIT) begin
                        cause[CAUSE_ANG_FAULT] = 1'b1;
                        ang_fails_next         = '0;
                    end else begin
                        ang_fails_next = ang_inc;
                    end
                end else begin
                    ang_fails_next = '0;
                end
                if (cause != '0) begin
                    stuck_next = 1'b1;
                end
            end
        end

        result.stuck      = stuck_next;
        result.stuck_new  = (cause != '0);
        result.cause_mask = cause;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_dist_err_reg <= '0;
            last_ang_err_reg  <= '0;
            dist_fails_reg    <= '0;
            ang_fails_reg     <= '0;
            stuck_reg         <= 1'b0;
        end else if (step) begin
            last_dist_err_reg <= last_dist_err_next;
            last_ang_err_reg  <= last_ang_err_next;
            dist_fails_reg    <= dist_fails_next;
            ang_fails_reg     <= ang_fails_next;
            stuck_reg         <= stuck_next;
        end
    end

    // The counters wrap to zero once they pass the limit.
    a_dist_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        dist_fails_reg <= LIMIT)
        else $error("distance fault counter above limit");

    a_ang_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ang_fails_reg <= LIMIT)
        else $error("angle fault counter above limit");

    // While stuck, no check runs, so the counters stay put on a control tick.
    a_stuck_freezes: assert property (@(posedge aclk) disable iff (!aresetn)
        step && stuck_reg && item.func == FUNC_TICK |=>
            $stable(dist_fails_reg) && $stable(ang_fails_reg) && stuck_reg)
        else $error("counters moved while stuck");

    a_clear_works: assert property (@(posedge aclk) disable iff (!aresetn)
        step && item.func == FUNC_CLEAR |=>
            !stuck_reg && dist_fails_reg == '0 && ang_fails_reg == '0)
        else $error("clear word left stuck state behind");

endmodule

@@ dv/motion_stall_detector_top_test.sv @@
// Self-checking testbench for the motion stall detector: directed, persistence and random traffic.
module motion_stall_detector_top_test;
    import msd_pkg::*;

    localparam int FAIL_LIMIT    = 50;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_LIMIT   = 4000;
    // Spare cycles waited once the queue of expected results has emptied.
    localparam int SETTLE_CYCLES = 6;

    localparam logic signed [VAL_W-1:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] Q_MAX = 32'sh7FFF_FFFF;

    // Threshold values that the block loads at reset.
    localparam logic [CFG_W-1:0] RST_DIST_JUMP     = 31'd16384;
    localparam logic [CFG_W-1:0] RST_ANG_JUMP      = 31'd183501;
    localparam logic [CFG_W-1:0] RST_CMD_STALL     = 31'd40960;
    localparam logic [CFG_W-1:0] RST_REVERSE_SPEED = 31'd16384;
    localparam logic [CFG_W-1:0] RST_STALL_SPEED   = 31'd9830;
    localparam logic [CFG_W-1:0] RST_ANG_FLOOR     = 31'd6554;
    localparam logic [CFG_W-1:0] RST_TURN_FLOOR    = 31'd262;
    localparam logic [CFG_W-1:0] RST_DETECT_EN     = 31'd1;

    // Register indexes that decode to nothing.
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_FIRST = 4'd8;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LAST  = 4'd15;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_wr_en;
    logic [CFG_ADDR_W-1:0]  cfg_addr;
    logic [CFG_W-1:0]       cfg_wdata;

    // Predictor state: our own copy of the thresholds, error history, fault run
    // counters and the sticky flag.
    logic [CFG_W-1:0]  thresholds [8];
    logic [CFG_W-1:0]  next_settings [8];
    longint            prev_dist_err;
    longint            prev_ang_err;
    logic [CNT_W-1:0]  dist_fail_run;
    logic [CNT_W-1:0]  ang_fail_run;
    logic              stuck_held;

    msd_result_t       stall_verdicts_due [$];
    int                mismatch_count;
    int                words_sent;
    int                cycle_count;
    int                tx_idle_pct;
    int                rx_idle_pct;

    motion_stall_detector_top #(
        .FAIL_LIMIT (FAIL_LIMIT)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Predictor helpers
    // ------------------------------------------------------------------

    function automatic longint q_magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic int q_sign(input longint v);
        return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    function automatic longint limit_of(input cfg_reg_t r);
        return longint'(thresholds[r]);
    endfunction

    // Computes the result word for one accepted input word and advances the
    // predictor state exactly as the block is meant to.
    function automatic msd_result_t predict_stall_verdict(input msd_item_t w);
        msd_result_t verdict;
        longint      de;
        longint      ae;
        longint      lv;
        longint      av;
        longint      dc;
        logic        dist_bad;
        logic        ang_bad;
        verdict = '0;
        if (w.func == FUNC_CLEAR) begin
            // Clear drops the counters and the flag but keeps the error history.
            dist_fail_run = '0;
            ang_fail_run  = '0;
            stuck_held    = 1'b0;
        end else begin
            de = longint'($signed(w.dist_err));
            ae = longint'($signed(w.ang_err));
            lv = longint'($signed(w.lin_speed));
            av = longint'($signed(w.ang_speed));
            dc = longint'($signed(w.dist_cmd));
            if (w.active && thresholds[REG_DETECT_EN][0] && !stuck_held) begin
                verdict.cause_mask[CAUSE_DIST_JUMP] =
                    q_magnitude(de - prev_dist_err) > limit_of(REG_DIST_JUMP);
                dist_bad = (q_sign(de) != q_sign(lv) &&
                            q_magnitude(lv) > limit_of(REG_REVERSE_SPEED)) ||
                           (q_magnitude(dc) > limit_of(REG_CMD_STALL) &&
                            q_magnitude(lv) < limit_of(REG_STALL_SPEED));
                if (dist_bad) begin
                    dist_fail_run = dist_fail_run + 1'b1;
                    if (dist_fail_run > FAIL_LIMIT) begin
                        verdict.cause_mask[CAUSE_DIST_FAULT] = 1'b1;
                        dist_fail_run = '0;
                    end
                end else begin
                    dist_fail_run = '0;
                end

                verdict.cause_mask[CAUSE_ANG_JUMP] =
                    q_magnitude(ae - prev_ang_err) > limit_of(REG_ANG_JUMP);
                ang_bad = q_magnitude(ae) > limit_of(REG_ANG_FLOOR) &&
                          (q_sign(ae) != q_sign(av) ||
                           q_magnitude(av) < limit_of(REG_TURN_FLOOR));
                if (ang_bad) begin
                    ang_fail_run = ang_fail_run + 1'b1;
                    if (ang_fail_run > FAIL_LIMIT) begin
                        verdict.cause_mask[CAUSE_ANG_FAULT] = 1'b1;
                        ang_fail_run = '0;
                    end
                end else begin
                    ang_fail_run = '0;
                end

                if (|verdict.cause_mask) begin
                    stuck_held        = 1'b1;
                    verdict.stuck_new = 1'b1;
                end
            end
            // History is kept on every tick, idle or not.
            prev_dist_err = de;
            prev_ang_err  = ae;
        end
        verdict.stuck = stuck_held;
        return verdict;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic signed [VAL_W-1:0] sat_q(input longint v);
        if (v > longint'(Q_MAX)) return Q_MAX;
        if (v < longint'(Q_MIN)) return Q_MIN;
        return VAL_W'(v);
    endfunction

    function automatic int q_rand_sign();
        return $urandom_range(1) ? 1 : -1;
    endfunction

    // A value strictly above, or strictly below, the current threshold (zero when it is zero).
    function automatic longint past_level(input cfg_reg_t r);
        return limit_of(r) + longint'($urandom_range(1, 4096));
    endfunction

    function automatic longint short_of_level(input cfg_reg_t r);
        if (limit_of(r) == 0) return 0;
        return longint'($urandom_range(0, 32'(limit_of(r) - 1)));
    endfunction

    function automatic logic signed [VAL_W-1:0] rand_q16();
        case ($urandom_range(4))
            0: return sat_q(longint'($urandom_range(0, 262144)) - 131072);
            1: return '0;
            2: begin
                case ($urandom_range(3))
                    0: return Q_MIN;
                    1: return Q_MAX;
                    2: return -1;
                    default: return 1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic msd_item_t make_tick(input logic act,
                                            input logic signed [VAL_W-1:0] de,
                                            input logic signed [VAL_W-1:0] ae,
                                            input logic signed [VAL_W-1:0] lv,
                                            input logic signed [VAL_W-1:0] av,
                                            input logic signed [VAL_W-1:0] dc);
        msd_item_t w;
        w.func      = FUNC_TICK;
        w.active    = act;
        w.dist_err  = de;
        w.ang_err   = ae;
        w.lin_speed = lv;
        w.ang_speed = av;
        w.dist_cmd  = dc;
        return w;
    endfunction

    // A clear word carries random payload, which the block must ignore.
    function automatic msd_item_t make_clear();
        msd_item_t w;
        w.func      = FUNC_CLEAR;
        w.active    = 1'($urandom_range(1));
        w.dist_err  = $urandom;
        w.ang_err   = $urandom;
        w.lin_speed = $urandom;
        w.ang_speed = $urandom;
        w.dist_cmd  = $urandom;
        return w;
    endfunction

    function automatic msd_item_t random_word();
        msd_item_t w;
        w = make_tick(1'($urandom_range(1)), rand_q16(), rand_q16(), rand_q16(),
                      rand_q16(), rand_q16());
        w.func = ($urandom_range(99) < 10) ? FUNC_CLEAR : FUNC_TICK;
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Offers one word, with random idle cycles in front of it, and records the
    // predicted result once the word is taken.
    task automatic send_word(input msd_item_t w);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= w.func;
        s_tdata  <= IN_TDATA_W'({w.dist_cmd, w.ang_speed, w.lin_speed, w.ang_err,
                                 w.dist_err, w.active});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        stall_verdicts_due = {stall_verdicts_due, predict_stall_verdict(w)};
        words_sent++;
    endtask

    // Stops offering words and waits until every expected result has come back or the drain limit runs out.
    task automatic drain_results();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (stall_verdicts_due.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic stage_reset_values();
        next_settings[REG_DIST_JUMP]     = RST_DIST_JUMP;
        next_settings[REG_ANG_JUMP]      = RST_ANG_JUMP;
        next_settings[REG_CMD_STALL]     = RST_CMD_STALL;
        next_settings[REG_REVERSE_SPEED] = RST_REVERSE_SPEED;
        next_settings[REG_STALL_SPEED]   = RST_STALL_SPEED;
        next_settings[REG_ANG_FLOOR]     = RST_ANG_FLOOR;
        next_settings[REG_TURN_FLOOR]    = RST_TURN_FLOOR;
        next_settings[REG_DETECT_EN]     = RST_DETECT_EN;
    endtask

    // Writes all eight registers from next_settings back to back, then one
    // write to an index that decodes to nothing. Only called while idle.
    task automatic program_registers();
        for (int i = REG_DIST_JUMP; i <= REG_DETECT_EN; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_addr  <= CFG_ADDR_W'(i);
            cfg_wdata <= next_settings[i];
            @(posedge aclk);
            // Only bit 0 of the enable register is stored.
            thresholds[i] = (i == REG_DETECT_EN) ? CFG_W'(next_settings[i][0])
                                                 : next_settings[i];
        end
        cfg_addr  <= CFG_ADDR_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST));
        cfg_wdata <= CFG_W'($urandom);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic restore_reset_values();
        drain_results();
        stage_reset_values();
        program_registers();
    endtask

    task automatic hold_tick(input int n, input logic act,
                             input logic signed [VAL_W-1:0] de,
                             input logic signed [VAL_W-1:0] ae,
                             input logic signed [VAL_W-1:0] lv,
                             input logic signed [VAL_W-1:0] av,
                             input logic signed [VAL_W-1:0] dc);
        repeat (n) send_word(make_tick(act, de, ae, lv, av, dc));
    endtask

    // A handful of words that sweep the field extremes under whatever
    // thresholds are loaded.
    task automatic send_probe_words();
        send_word(make_clear());
        send_word(make_tick(1'b1, 0, 0, 0, 0, 0));
        send_word(make_tick(1'b1, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
        send_word(make_clear());
        send_word(make_tick(1'b1, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
        send_word(make_clear());
        send_word(make_tick(1'b1, 1, -1, -1, 1, 1));
        send_word(make_tick(1'b1, rand_q16(), rand_q16(), rand_q16(), rand_q16(),
                            rand_q16()));
    endtask

    // A run of ticks with slowly drifting errors and speeds chosen against the
    // present thresholds, so fault counters can build up to the limit. Rare
    // jumps and speed flips break runs at random points, and idle ticks pause them.
    task automatic send_steady_run();
        int     run_len;
        longint de;
        longint ae;
        longint lv;
        longint av;
        longint dc;
        longint step_d;
        longint step_a;
        run_len = ($urandom_range(99) < 45) ? $urandom_range(45, 70) : $urandom_range(1, 30);
        if ($urandom_range(99) < 80) send_word(make_clear());
        de = q_rand_sign() * longint'($urandom_range(0, 131072));
        ae = q_rand_sign() * (limit_of(REG_ANG_FLOOR) + longint'($urandom_range(1, 32768)));
        dc = q_rand_sign() * longint'($urandom_range(0, 32768));
        case ($urandom_range(3))
            0: lv = -q_sign(de) * past_level(REG_REVERSE_SPEED);
            1: begin
                dc = q_rand_sign() * past_level(REG_CMD_STALL);
                lv = q_rand_sign() * short_of_level(REG_STALL_SPEED);
            end
            2: lv = ((de < 0) ? -1 : 1) * past_level(REG_REVERSE_SPEED);
            default: lv = longint'($signed(rand_q16()));
        endcase
        case ($urandom_range(3))
            0: av = -q_sign(ae) * past_level(REG_TURN_FLOOR);
            1: av = q_rand_sign() * short_of_level(REG_TURN_FLOOR);
            2: av = q_sign(ae) * past_level(REG_TURN_FLOOR);
            default: av = longint'($signed(rand_q16()));
        endcase
        step_d = limit_of(REG_DIST_JUMP) / 2;
        step_a = limit_of(REG_ANG_JUMP) / 2;
        if (step_d > 2048) step_d = 2048;
        if (step_a > 2048) step_a = 2048;
        for (int k = 0; k < run_len; k++) begin
            if ($urandom_range(199) < 3)
                de += q_rand_sign() * longint'($urandom_range(0, 262144));
            else
                de += q_rand_sign() * longint'($urandom_range(0, 32'(step_d)));
            if ($urandom_range(199) < 3)
                ae += q_rand_sign() * longint'($urandom_range(0, 1048576));
            else
                ae += q_rand_sign() * longint'($urandom_range(0, 32'(step_a)));
            if ($urandom_range(199) == 0) lv = -lv;
            if ($urandom_range(199) == 0) av = -av;
            de = longint'(sat_q(de));
            ae = longint'(sat_q(ae));
            send_word(make_tick($urandom_range(99) < 95, sat_q(de), sat_q(ae), sat_q(lv),
                                sat_q(av), sat_q(dc)));
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Threshold edges, the full signed range, idle ticks, the sticky flag and
    // clears, all under the reset thresholds.
    task automatic test_edge_items();
        // Change exactly at the jump limit is not a jump; one more is.
        send_word(make_tick(1'b1, 0, 0, 0, 0, 0));
        send_word(make_tick(1'b1, 16384, 0, 0, 0, 0));
        send_word(make_tick(1'b1, 16384 + 16385, 0, 0, 0, 0));
        // Flag is already set: no checks, no new cause.
        send_word(make_tick(1'b1, 32769, 0, 0, 0, 0));
        send_word(make_clear());
        // Inactive tick only records the history.
        send_word(make_tick(1'b0, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN));
        // Swing across the whole range on both axes.
        send_word(make_tick(1'b1, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX));
        send_word(make_clear());
        // Angle change exactly at its limit, then one past it.
        send_word(make_tick(1'b1, Q_MAX, Q_MIN + 183501, 0, -1, 0));
        send_word(make_tick(1'b1, Q_MAX, Q_MIN + 2 * 183501 + 1, 0, -1, 0));
        send_word(make_clear());
        // Zero error against a fast speed, same signs, and a huge command.
        send_word(make_tick(1'b1, Q_MAX, 0, 16385, 0, 0));
        send_word(make_tick(1'b1, Q_MAX, 0, Q_MIN, 0, Q_MIN));
        send_word(make_tick(1'b1, Q_MAX - 5, 6555, Q_MAX, 262, 40961));
        send_word(make_tick(1'b1, Q_MAX - 5, -6555, -16384, 261, 40960));
        send_word(make_tick(1'b1, Q_MAX, 6554, 9829, Q_MIN, -40961));
        send_word(make_clear());
        send_word(make_tick(1'b1, Q_MAX, 0, 0, 0, 0));
    endtask

    // Faults that persist past the limit on each axis, with runs broken by a
    // healthy tick and held across idle ticks.
    task automatic test_fault_persistence();
        send_word(make_clear());
        send_word(make_tick(1'b1, 1000, 0, 0, 0, 0));
        // Moving against the distance error.
        hold_tick(FAIL_LIMIT + 1, 1'b1, 1000, 0, -20000, 0, 0);
        send_word(make_clear());
        // One healthy tick restarts the count.
        hold_tick(FAIL_LIMIT, 1'b1, 1000, 0, -20000, 0, 0);
        hold_tick(1, 1'b1, 1000, 0, 0, 0, 0);
        hold_tick(FAIL_LIMIT + 1, 1'b1, 1000, 0, -20000, 0, 0);
        send_word(make_clear());
        // Idle ticks hold the count.
        hold_tick(30, 1'b1, 1000, 0, -20000, 0, 0);
        hold_tick(5, 1'b0, 1000, 0, -20000, 0, 0);
        hold_tick(FAIL_LIMIT + 1 - 30, 1'b1, 1000, 0, -20000, 0, 0);
        send_word(make_clear());
        // Large command while barely moving.
        hold_tick(FAIL_LIMIT + 1, 1'b1, 1000, 0, 100, 0, -50000);
        send_word(make_clear());
        // Turning too slowly, then turning the wrong way.
        hold_tick(FAIL_LIMIT + 1, 1'b1, 1000, 10000, 0, 0, 0);
        send_word(make_clear());
        hold_tick(FAIL_LIMIT + 1, 1'b1, 1000, -10000, 0, 5000, 0);
        send_word(make_clear());
        // Both axes reach the limit on the same tick.
        hold_tick(FAIL_LIMIT + 1, 1'b1, 1000, 10000, -20000, 0, 0);
        send_word(make_clear());
    endtask

    // Every threshold at zero, every register at its maximum, detection switched
    // off through an even value, and back to the reset values.
    task automatic test_register_settings();
        drain_results();
        for (int i = REG_DIST_JUMP; i <= REG_DETECT_EN; i++) next_settings[i] = '0;
        next_settings[REG_DETECT_EN] = 31'd1;
        program_registers();
        send_probe_words();

        drain_results();
        for (int i = REG_DIST_JUMP; i <= REG_DETECT_EN; i++) next_settings[i] = '1;
        program_registers();
        send_probe_words();

        drain_results();
        stage_reset_values();
        next_settings[REG_DETECT_EN] = 31'd2;
        program_registers();
        send_probe_words();
        hold_tick(FAIL_LIMIT + 2, 1'b1, 1000, 10000, -20000, 0, 0);

        restore_reset_values();
        send_probe_words();
    endtask

    task automatic test_random_traffic(input int n_words);
        int target;
        target = words_sent + n_words;
        while (words_sent < target) begin
            if ($urandom_range(99) < 25) begin
                repeat ($urandom_range(1, 6)) send_word(random_word());
            end else begin
                send_steady_run();
            end
        end
    endtask

    // Random traffic under random mid-range thresholds.
    task automatic test_tuned_traffic(input int n_words);
        drain_results();
        for (int i = REG_DIST_JUMP; i < REG_DETECT_EN; i++)
            next_settings[i] = CFG_W'($urandom_range(1000, 200000));
        next_settings[REG_TURN_FLOOR] = CFG_W'($urandom_range(10, 2000));
        next_settings[REG_DETECT_EN]  = 31'd1;
        program_registers();
        test_random_traffic(n_words);
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0d] mismatch: %s", cycle_count, what);
    endtask

    // The receiver stalls at random; m_tready is sampled here before this
    // edge's update takes effect, so the check sees what the block saw.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge aclk) begin : result_check
        msd_result_t seen;
        msd_result_t due;
        if (aresetn && m_tvalid && m_tready) begin
            seen.stuck      = m_tdata[0];
            seen.stuck_new  = m_tdata[1];
            seen.cause_mask = m_tdata[5:2];
            if (stall_verdicts_due.size() == 0) begin
                report_mismatch($sformatf("result word %h with nothing expected", m_tdata));
            end else begin
                due = stall_verdicts_due.pop_front();
                if (seen.stuck !== due.stuck)
                    report_mismatch($sformatf("stuck %b, expected %b",
                                              seen.stuck, due.stuck));
                if (seen.stuck_new !== due.stuck_new)
                    report_mismatch($sformatf("stuck_new %b, expected %b",
                                              seen.stuck_new, due.stuck_new));
                if (seen.cause_mask !== due.cause_mask)
                    report_mismatch($sformatf("cause_mask %b, expected %b",
                                              seen.cause_mask, due.cause_mask));
            end
        end
    end

    // Watchdog: ends a run that hangs.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_addr  <= '0;
        cfg_wdata <= '0;
        mismatch_count = 0;
        words_sent     = 0;
        tx_idle_pct    = 20;
        rx_idle_pct    = 54;
        stage_reset_values();
        thresholds     = next_settings;
        prev_dist_err  = 0;
        prev_ang_err   = 0;
        dist_fail_run  = '0;
        ang_fail_run   = '0;
        stuck_held     = 1'b0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Sender idles lightly, receiver stalls often.
        test_edge_items();
        test_fault_persistence();
        test_random_traffic(160);

        // The other way round.
        tx_idle_pct = 54;
        rx_idle_pct = 20;
        test_register_settings();
        test_tuned_traffic(160);

        // Full rate on both sides.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        restore_reset_values();
        test_random_traffic(160);

        drain_results();
        if (stall_verdicts_due.size() != 0)
            report_mismatch($sformatf("%0d result words never arrived",
                                      stall_verdicts_due.size()));
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/msd_pkg.sv
hw/rtl/msd_cfg.sv
hw/rtl/msd_core.sv
hw/rtl/motion_stall_detector_top.sv
dv/motion_stall_detector_top_test.sv
